// ----- hdl/pkt_pkg.sv -----
`default_nettype none
// ============================================================================
// pkt_pkg
// Shared types, constants and helper functions of the port knock tracker.
// ============================================================================
package pkt_pkg;

    // Protocol numbers that take part in knocking.
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Knock stages.
    localparam logic [1:0] STAGE_CLOSED = 2'd0;
    localparam logic [1:0] STAGE_FIRST  = 2'd1;
    localparam logic [1:0] STAGE_SECOND = 2'd2;
    localparam logic [1:0] STAGE_OPEN   = 2'd3;

    // Reset values of the knock port registers.
    localparam logic [15:0] KNOCK_FIRST_RST  = 16'd100;
    localparam logic [15:0] KNOCK_SECOND_RST = 16'd101;
    localparam logic [15:0] KNOCK_THIRD_RST  = 16'd102;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KNOCK_FIRST  = 2'd0,
        REG_KNOCK_SECOND = 2'd1,
        REG_KNOCK_THIRD  = 2'd2
    } cfg_reg_t;

    // Channel payloads.
    typedef struct packed {
        logic [31:0] dest_addr;
        logic [15:0] dest_port_num;
        logic [7:0]  proto_num;
    } hdr_t;

    typedef struct packed {
        logic       is_open;
        logic [1:0] knock_stage;
        logic       table_full;
    } res_t;

    // One row of the address table.
    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  stage;
    } entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_RESOLVE
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic check;
        logic resolve;
    } pkt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic hit;
    } pkt_sts_t;

    // Knock sequence step: advance on the expected port, otherwise close.
    function automatic logic [1:0] next_stage(
        input logic [1:0]  stage,
        input logic [15:0] port,
        input logic [15:0] first,
        input logic [15:0] second,
        input logic [15:0] third
    );
        logic [1:0] res;
        res = STAGE_CLOSED;
        if (stage == STAGE_CLOSED && port == first)
            res = STAGE_FIRST;
        else if (stage == STAGE_FIRST && port == second)
            res = STAGE_SECOND;
        else if (stage == STAGE_SECOND && port == third)
            res = STAGE_OPEN;
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pkt_if.sv -----
`default_nettype none
// ============================================================================
// pkt_if
// Valid/ready stream interface and configuration write interface.
// ============================================================================
interface pkt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pkt_cfg_if import pkt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pkt_ctrl.sv -----
`default_nettype none
// ============================================================================
// pkt_ctrl
// Controller of the port knock tracker: sequences the table scan, the
// update and the result handshake.
// ============================================================================
module pkt_ctrl import pkt_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire pkt_sts_t sts,
    output pkt_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (sts.scan_done)
                    state_next = ST_RESOLVE;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.hit)
                    state_next = ST_RESOLVE;
                else
                    state_next = ST_READ;
            end
            ST_RESOLVE:
            begin
                // The result register must be free before it is overwritten.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.resolve    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // A new result is produced only from the resolve state.
    a_res_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_valid_reg) && out_valid_reg |-> $past(state_reg) == ST_RESOLVE)
        else $error("result raised outside resolve");

    // Every accepted header starts a scan.
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_READ)
        else $error("accepted header did not start a scan");

    // A check is always preceded by a table read.
    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CHECK |-> $past(state_reg) == ST_READ)
        else $error("check without a table read");

endmodule
`default_nettype wire

// ----- hdl/pkt_dp.sv -----
`default_nettype none
// ============================================================================
// pkt_dp
// Datapath of the port knock tracker: knock port registers, address table,
// scan counter, stage update and result register.
// ============================================================================
module pkt_dp import pkt_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire hdr_t                 hdr_data,
    output res_t                      res_data,
    input  wire pkt_cmd_t             cmd,
    output pkt_sts_t                  sts
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    logic [15:0]      port_first_reg;
    logic [15:0]      port_second_reg;
    logic [15:0]      port_third_reg;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             found_reg;
    hdr_t             hdr_reg;
    entry_t           rd_data_reg;
    res_t             res_reg;
    entry_t           tbl_mem [TABLE_ENTRIES];

    logic             is_knock_proto;
    logic             full;
    logic [1:0]       base_stage;
    logic [1:0]       new_stage;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    // Knock port registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_first_reg  <= KNOCK_FIRST_RST;
            port_second_reg <= KNOCK_SECOND_RST;
            port_third_reg  <= KNOCK_THIRD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KNOCK_FIRST:  port_first_reg  <= cfg_data;
                REG_KNOCK_SECOND: port_second_reg <= cfg_data;
                REG_KNOCK_THIRD:  port_third_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Stage update for the current header.
    always_comb
    begin
        is_knock_proto = (hdr_reg.proto_num == PROTO_TCP) ||
                         (hdr_reg.proto_num == PROTO_UDP);
        full           = !found_reg && (fill_count_reg == CNT_FULL);
        base_stage     = found_reg ? rd_data_reg.stage : STAGE_CLOSED;
        new_stage      = is_knock_proto ?
                         next_stage(base_stage, hdr_reg.dest_port_num,
                                    port_first_reg, port_second_reg,
                                    port_third_reg) :
                         base_stage;
        wr_en          = cmd.resolve && (found_reg ? is_knock_proto : !full);
        wr_idx         = found_reg ? scan_cnt_reg[IDX_W-1:0] :
                                     fill_count_reg[IDX_W-1:0];
    end

    // Scan control: fill count, scan position and hit flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            scan_cnt_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.check)
            begin
                found_reg <= sts.hit;
                if (!sts.hit)
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (cmd.resolve && !found_reg && !full)
                fill_count_reg <= fill_count_reg + CNT_W'(1);
        end
    end

    // Header capture and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            hdr_reg <= hdr_data;
        if (cmd.resolve)
        begin
            res_reg.is_open     <= (new_stage == STAGE_OPEN);
            res_reg.knock_stage <= new_stage;
            res_reg.table_full  <= full;
        end
    end

    // Address table: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            tbl_mem[wr_idx] <= '{addr: hdr_reg.dest_addr, stage: new_stage};
        if (cmd.rd_en)
            rd_data_reg <= tbl_mem[scan_cnt_reg[IDX_W-1:0]];
    end

    assign sts.scan_done = (scan_cnt_reg == fill_count_reg);
    assign sts.hit       = (rd_data_reg.addr == hdr_reg.dest_addr);
    assign res_data      = res_reg;

    // The table never holds more entries than it has rows.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_FULL)
        else $error("fill count beyond table size");

    // The scan never runs past the filled part of the table.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= fill_count_reg)
        else $error("scan past filled entries");

    // The fill count only grows by one, and only on a resolve.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg != $past(fill_count_reg) |->
            fill_count_reg == $past(fill_count_reg) + CNT_W'(1) && $past(cmd.resolve))
        else $error("unexpected fill count change");

endmodule
`default_nettype wire

// ----- hdl/port_knock_tracker_top.sv -----
`default_nettype none
// ============================================================================
// port_knock_tracker_top
// Three-knock port knock tracker over a table of destination addresses.
// ============================================================================
//  Channel  Direction  Payload                                   Handshake
//  hdr      in         dest_addr, dest_port_num, proto_num       valid/ready
//  res      out        is_open, knock_stage, table_full          valid/ready
//  cfg      in         index, data (knock ports 0..2)            valid/ready
//
//  A header is scanned entry by entry from acceptance until it matches a
//  stored entry or passes all stored entries; each compared entry costs one
//  table read plus one compare on the single read port of the address
//  table. The result register frees the result side: a new header is
//  accepted while a result still waits, but its own result holds in resolve
//  until the waiting one is taken.
//  Reset clears the knock ports to 100, 101, 102 and empties the table.
//  cfg is always ready.
// ============================================================================
module port_knock_tracker_top import pkt_pkg::*; #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pkt_stream_if.sink   hdr,
    pkt_stream_if.source res,
    pkt_cfg_if.sink      cfg
);

    pkt_cmd_t cmd;
    pkt_sts_t sts;
    hdr_t     hdr_data;
    res_t     res_data;

    assign cfg.ready = 1'b1;
    assign hdr_data  = hdr.data;
    assign res.data  = res_data;

    // Sequencing of scan, update and result handshake.
    pkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hdr.valid),
        .in_ready  (hdr.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Table, registers and stage logic.
    pkt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .hdr_data  (hdr_data),
        .res_data  (res_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
